// File: design/evg_pkg.sv
package evg_pkg;

  // Word and result widths
  localparam int unsigned WordBits   = 32;
  localparam int unsigned LeadBits   = 5;
  localparam int unsigned IndexBits  = 4;
  localparam int unsigned VarBits    = 37;
  localparam int unsigned InDataBits = 32;
  localparam int unsigned OutDataBits = 40;
  localparam int unsigned TableDepth = 16;

  // ln2 as a Q0.32 fraction, rounded to nearest
  localparam logic [WordBits-1:0] Ln2Q32 = 32'd2977044472;
  localparam logic [WordBits:0]   OneQ32 = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEED   = 2'd1,
    PH_SEARCH = 2'd2
  } phase_e;

  typedef struct packed {
    logic               emit;
    logic [VarBits-1:0] variate;
  } evg_result_t;

  // Partial sums of ln2^i/i!, Q0.32; the last entry in use is forced to 1.0
  function automatic logic [WordBits:0] q_entry(input logic [IndexBits-1:0] idx);
    logic [WordBits:0] q;
    case (idx)
      4'd0:    q = 33'd2977044472;
      4'd1:    q = 33'd4008809463;
      4'd2:    q = 33'd4247197794;
      4'd3:    q = 33'd4288507344;
      4'd4:    q = 33'd4294234064;
      4'd5:    q = 33'd4294895641;
      4'd6:    q = 33'd4294961151;
      4'd7:    q = 33'd4294966827;
      4'd8:    q = 33'd4294967264;
      4'd9:    q = 33'd4294967294;
      default: q = OneQ32;
    endcase
    if ({28'd0, idx} >= TableDepth - 1) begin
      q = OneQ32;
    end
    return q;
  endfunction

endpackage

// File: design/evg_lzc.sv
module evg_lzc
  import evg_pkg::*;
(
  input  logic [WordBits-1:0] word_i,
  output logic [LeadBits-1:0] lead_o,
  output logic [WordBits-1:0] frac_o
);

  logic [WordBits-1:0] s16, s8, s4, s2, s1;

  // Normalize in five binary steps, one count bit per step
  always_comb begin
    lead_o[4] = (word_i[31:16] == 16'd0);
    s16       = lead_o[4] ? {word_i[15:0], 16'd0} : word_i;
    lead_o[3] = (s16[31:24] == 8'd0);
    s8        = lead_o[3] ? {s16[23:0], 8'd0} : s16;
    lead_o[2] = (s8[31:28] == 4'd0);
    s4        = lead_o[2] ? {s8[27:0], 4'd0} : s8;
    lead_o[1] = (s4[31:30] == 2'd0);
    s2        = lead_o[1] ? {s4[29:0], 2'd0} : s4;
    lead_o[0] = ~s2[31];
    s1        = lead_o[0] ? {s2[30:0], 1'b0} : s2;
  end

  // Drop the leading one to leave the fraction below it
  assign frac_o = {s1[30:0], 1'b0};

endmodule

// File: design/evg_sampler.sv
module evg_sampler
  import evg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [WordBits-1:0] word_i,
  input  logic [LeadBits-1:0] lead_i,
  input  logic [WordBits-1:0] frac_i,
  output evg_result_t         result_o
);

  phase_e               phase_q, phase_d;
  logic [LeadBits-1:0]  lead_q, lead_d;
  logic [WordBits-1:0]  frac_q, frac_d;
  logic [IndexBits-1:0] index_q, index_d;
  logic [WordBits-1:0]  min_q, min_d;

  logic [WordBits-1:0]  new_min;
  logic [IndexBits-1:0] next_index;
  logic                 first_ok;
  logic                 search_ok;
  logic [2*WordBits-1:0] min_prod;
  logic [VarBits-1:0]   lead_prod_in;
  logic [VarBits-1:0]   lead_prod_st;

  // Shared compares for the draw in hand
  assign new_min    = (word_i < min_q) ? word_i : min_q;
  assign next_index = index_q + 1'b1;
  assign first_ok   = ({1'b0, frac_i} <= {1'b0, Ln2Q32});
  assign search_ok  = ({1'b0, frac_q} <= q_entry(next_index));

  // Next state
  always_comb begin
    phase_d = phase_q;
    lead_d  = lead_q;
    frac_d  = frac_q;
    index_d = index_q;
    min_d   = min_q;
    if (advance_i) begin
      case (phase_q)
        PH_SEED: begin
          min_d   = word_i;
          index_d = '0;
          phase_d = PH_SEARCH;
        end
        PH_SEARCH: begin
          min_d   = new_min;
          index_d = next_index;
          if (search_ok) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (word_i != '0) begin
            lead_d = lead_i;
            frac_d = frac_i;
            if (!first_ok) begin
              phase_d = PH_SEED;
            end
          end
        end
      endcase
    end
  end

  // Result value and emit flag
  always_comb begin
    lead_prod_in = VarBits'(lead_i) * VarBits'(Ln2Q32);
    lead_prod_st = VarBits'(lead_q) * VarBits'(Ln2Q32);
    min_prod     = (2*WordBits)'(new_min) * (2*WordBits)'(Ln2Q32);
    result_o     = '0;
    case (phase_q)
      PH_SEED: begin
        result_o.emit = 1'b0;
      end
      PH_SEARCH: begin
        result_o.emit    = search_ok;
        result_o.variate = lead_prod_st + VarBits'(min_prod[2*WordBits-1:WordBits]);
      end
      default: begin
        result_o.emit    = (word_i != '0) && first_ok;
        result_o.variate = lead_prod_in + VarBits'(frac_i);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lead_q  <= '0;
      frac_q  <= '0;
      index_q <= '0;
      min_q   <= '0;
    end else begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      frac_q  <= frac_d;
      index_q <= index_d;
      min_q   <= min_d;
    end
  end

`ifndef SYNTHESIS
  a_zero_first_draw_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_SEED && phase_q != PH_SEARCH && word_i == '0) |-> !result_o.emit)
    else $error("zero first draw produced a result");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && result_o.emit) |=> phase_q == PH_IDLE)
    else $error("phase not idle after a result");

  a_seed_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && phase_q == PH_SEED) |=> (phase_q == PH_SEARCH && index_q == '0))
    else $error("seed draw did not start the table search");

  a_min_never_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && phase_q == PH_SEARCH) |=> min_q <= $past(min_q))
    else $error("running minimum increased during search");
`endif

endmodule

// File: design/exponential_variate_generator_core.sv
// Each accepted word goes through one combinational pass (leading-zero normalize,
// compare, one 32x32 multiply) into the result register, which the master side reads.
// Throughput: one uniform word per cycle while the result register is free or draining.
// A variate needs one word, or three or more when the first fraction exceeds ln2.
// Reset: rst_ni low clears the phase to idle and empties the result register.
module exponential_variate_generator_core
  import evg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,   // [31:0] uniform_bits
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata    // [36:0] variate, [39:37] zero
);

  logic                advance;
  logic [LeadBits-1:0] lead;
  logic [WordBits-1:0] frac;
  evg_result_t         result;

  logic                out_valid_q, out_valid_d;
  logic [VarBits-1:0]  out_data_q, out_data_d;
  logic                load;

  // Take a request whenever the result register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign advance       = s_axis_tvalid && s_axis_tready;

  evg_lzc u_lzc (
    .word_i (s_axis_tdata),
    .lead_o (lead),
    .frac_o (frac)
  );

  evg_sampler u_sampler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .word_i    (s_axis_tdata),
    .lead_i    (lead),
    .frac_i    (frac),
    .result_o  (result)
  );

  // Load, hold or drain the result register
  assign load = advance && result.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = result.variate;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataBits-VarBits)'(0), out_data_q};

endmodule

// File: tb/evg_variate_checker.sv
module evg_variate_checker
  import evg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,   // [31:0] uniform_bits
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OutDataBits-1:0] m_axis_tdata,   // [36:0] variate, [39:37] zero
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VarMax = (64'd1 << VarBits) - 64'd1;

  // Shadow of the sampler state
  phase_e                draw_phase;
  logic [5:0]            lead_zeros;
  logic [WordBits-1:0]   frac_q32;
  logic [IndexBits-1:0]  bound_idx;
  logic [WordBits-1:0]   min_draw;

  logic [VarBits-1:0]    variate_q [$];
  int                    mismatches = 0;

  // Acceptance bound for the running-minimum search, Q0.32
  function automatic logic [WordBits:0] accept_bound(input logic [IndexBits-1:0] idx);
    logic [WordBits:0] bound;
    case (idx)
      4'd0:    bound = 33'd2977044472;
      4'd1:    bound = 33'd4008809463;
      4'd2:    bound = 33'd4247197794;
      4'd3:    bound = 33'd4288507344;
      4'd4:    bound = 33'd4294234064;
      4'd5:    bound = 33'd4294895641;
      4'd6:    bound = 33'd4294961151;
      4'd7:    bound = 33'd4294966827;
      4'd8:    bound = 33'd4294967264;
      4'd9:    bound = 33'd4294967294;
      default: bound = OneQ32;
    endcase
    return bound;
  endfunction

  // Clamp to the output range and queue one variate
  task automatic queue_variate(input logic [63:0] acc);
    logic [63:0] clamped;
    clamped = (acc > VarMax) ? VarMax : acc;
    variate_q.push_back(clamped[VarBits-1:0]);
  endtask

  // Advance the sampler by one accepted request
  task automatic take_draw(input logic [WordBits-1:0] draw);
    logic [WordBits-1:0] w;
    logic [5:0]          zeros;
    logic [63:0]         min_scaled;
    w = draw;
    case (draw_phase)
      PH_SEED: begin
        min_draw   = w;
        bound_idx  = '0;
        draw_phase = PH_SEARCH;
      end
      PH_SEARCH: begin
        if (w < min_draw) begin
          min_draw = w;
        end
        bound_idx = bound_idx + 4'd1;
        if ({1'b0, frac_q32} <= accept_bound(bound_idx)) begin
          min_scaled = (64'(min_draw) * 64'(Ln2Q32)) >> 32;
          queue_variate(64'(lead_zeros) * 64'(Ln2Q32) + min_scaled);
          draw_phase = PH_IDLE;
        end
      end
      default: begin
        // Zero first draw is dropped, phase stays idle
        draw_phase = PH_IDLE;
        if (w != '0) begin
          zeros = '0;
          while (!w[WordBits-1]) begin
            w     = w << 1;
            zeros = zeros + 6'd1;
          end
          lead_zeros = zeros;
          frac_q32   = w << 1;
          if (frac_q32 <= Ln2Q32) begin
            queue_variate(64'(lead_zeros) * 64'(Ln2Q32) + 64'(frac_q32));
          end else begin
            draw_phase = PH_SEED;
          end
        end
      end
    endcase
  endtask

  // Compare one response with the oldest queued variate
  task automatic check_variate(input logic [OutDataBits-1:0] got);
    logic [VarBits-1:0] want;
    if (variate_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected variate %h", $realtime, got);
      end
    end else begin
      want = variate_q.pop_front();
      if (got !== {{(OutDataBits-VarBits){1'b0}}, want}) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: variate mismatch, expected %h, got %h", $realtime,
                   {{(OutDataBits-VarBits){1'b0}}, want}, got);
        end
      end
    end
  endtask

  // Watch both channels; responses first, since they belong to earlier requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_phase = PH_IDLE;
      lead_zeros = '0;
      frac_q32   = '0;
      bound_idx  = '0;
      min_draw   = '0;
      variate_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_variate(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_draw(s_axis_tdata[WordBits-1:0]);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= variate_q.size();
  end

endmodule

// File: tb/tb_exponential_variate_generator_core.sv
module tb_exponential_variate_generator_core
  import evg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int tx_idle_pct = 26;
  int rx_idle_pct = 72;

  logic [31:0] corner_words [$];

  exponential_variate_generator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  evg_variate_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the response channel at random
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Pick a word, biased toward zeros, long zero runs and fractions near one
  function automatic logic [31:0] uniform_pick();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) begin
      return 32'h0000_0000;
    end else if (sel < 20) begin
      return $urandom >> $urandom_range(31);
    end else if (sel < 34) begin
      return 32'hFFF0_0000 | ($urandom & 32'h000F_FFFF);
    end
    return $urandom;
  endfunction

  // Offer one request, with random idle cycles ahead of it
  task automatic offer_word(input logic [31:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off until every queued variate has come back
  task automatic drain_variates();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Stimulus and verdict
  initial begin
    corner_words = '{
      32'h0000_0000,                      // zero first draw, dropped
      32'h0000_0001,                      // most leading zeros, zero fraction
      32'h8000_0000,                      // no leading zeros, zero fraction
      {1'b1, Ln2Q32[31:1]},               // fraction exactly ln2
      {1'b1, Ln2Q32[31:1]} + 32'd1,       // fraction just above ln2
      32'hFFFF_FFFF,                      // seed
      32'h0000_0000,                      // later zero draw clears the minimum
      32'hFFFF_FFFF,                      // largest fraction, deepest search
      32'h8765_4321,                      // seed
      32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_0000,
      32'hFFFF_FFFE, 32'h0000_0000, 32'h2000_0000,
      32'h1234_5678, 32'h7FFF_FFFF, 32'h0000_0002,
      32'h0000_0003,                      // many leading zeros, fraction below ln2
      32'hFFFF_FFFF,                      // largest fraction, starts a search
      32'hFFFF_FFFF
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_words[i]) begin
      offer_word(corner_words[i]);
    end
    repeat (400) offer_word(uniform_pick());
    drain_variates();

    tx_idle_pct <= 72;
    rx_idle_pct <= 26;
    repeat (400) offer_word(uniform_pick());

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    repeat (400) offer_word(uniform_pick());

    drain_variates();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
